/* rtl/core/psg2fm_pkg.sv */
// Shared types, constants and tables for the square-wave to FM register translator.
`timescale 1ns / 1ps

package psg2fm_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [30:0] CLOCK_HZ_RESET = 31'd3579545;
    localparam logic [21:0] FM_RATE_NUM    = 22'd3579545;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOCK_HZ  = 2'd0,
        REG_STEREO_EN = 2'd1,
        REG_TONE_MODE = 2'd2
    } cfg_reg_t;

    // noise feedback/connection words, selected by noise control bit 2
    localparam logic [3:0] NOISE_WORD_WHITE    = 4'hB;
    localparam logic [3:0] NOISE_WORD_PERIODIC = 4'hE;

    typedef enum logic [1:0] {
        CMD_STEREO,
        CMD_VOLUME,
        CMD_TONE,
        CMD_NOISE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  voice;
        logic        with_noise;
        logic [9:0]  tone_per;
        logic [10:0] noise_per;
        logic        noise_sel;
        logic [3:0]  vol;
        logic [1:0]  pan3;
        logic [7:0]  mask;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [18:0] d;
        logic        capped;
    } freq_req_t;

    typedef struct packed {
        logic        done;
        logic [2:0]  blk;
        logic [9:0]  fnum;
    } freq_rsp_t;

    function automatic logic [7:0] vol_map(input logic [3:0] v);
        logic [7:0] r;
        case (v)
            4'd0:  r = 8'h00;
            4'd1:  r = 8'h03;
            4'd2:  r = 8'h05;
            4'd3:  r = 8'h08;
            4'd4:  r = 8'h0B;
            4'd5:  r = 8'h0D;
            4'd6:  r = 8'h10;
            4'd7:  r = 8'h13;
            4'd8:  r = 8'h15;
            4'd9:  r = 8'h18;
            4'd10: r = 8'h1B;
            4'd11: r = 8'h1D;
            4'd12: r = 8'h20;
            4'd13: r = 8'h23;
            4'd14: r = 8'h25;
            default: r = 8'h3F;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/psg_to_fm_register_translator_top.sv */
// Volume and stereo items pass the command queue and sequencer state before their first FM
// write is registered. Tone items wait on one frequency result, noise items on one after
// three writes, noise-retuning tone writes on two; frequency: up to 8 block steps, 11 divide.
// Throughput: one item in service, two more held in the command queue.
// Reset: synchronous active-low aresetn restores chip registers, volumes and routing.
// Top level of the square-wave to FM register write translator.
`timescale 1ns / 1ps

module psg_to_fm_register_translator_top #(
    parameter int FIFO_DEPTH = psg2fm_pkg::FIFO_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,    // [7:0] wr_byte
    input  logic                             s_tuser,    // [0] op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,    // [7:0] fm_addr, [15:8] fm_value
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psg2fm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]                      cfg_data
);

    logic [30:0]           clock_hz_reg;
    logic                  stereo_en_reg;
    logic                  tone_mode_reg;

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    psg2fm_pkg::cmd_t      cmd_push;
    psg2fm_pkg::cmd_t      cmd_head;
    psg2fm_pkg::freq_req_t freq_req;
    psg2fm_pkg::freq_rsp_t freq_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg  <= psg2fm_pkg::CLOCK_HZ_RESET;
            stereo_en_reg <= 1'b0;
            tone_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                psg2fm_pkg::REG_CLOCK_HZ:  clock_hz_reg  <= cfg_data;
                psg2fm_pkg::REG_STEREO_EN: stereo_en_reg <= cfg_data[0];
                psg2fm_pkg::REG_TONE_MODE: tone_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    psg2fm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .op            (s_tuser),
        .wr_byte       (s_tdata),
        .stereo_enable (stereo_en_reg),
        .push          (push),
        .cmd           (cmd_push)
    );

    psg2fm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (cmd_push),
        .pop     (pop),
        .dout    (cmd_head),
        .full    (full),
        .empty   (empty)
    );

    psg2fm_freq u_freq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (freq_req),
        .clock_hz (clock_hz_reg),
        .rsp      (freq_rsp)
    );

    psg2fm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_in    (cmd_head),
        .empty     (empty),
        .pop       (pop),
        .tone_mode (tone_mode_reg),
        .freq_req  (freq_req),
        .freq_rsp  (freq_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("command queue underflow");

    a_full_by_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");
`endif

endmodule

/* rtl/core/psg2fm_fifo.sv */
// Small command queue between the decode front and the write sequencer.
`timescale 1ns / 1ps

module psg2fm_fifo #(
    parameter int DEPTH = psg2fm_pkg::FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  psg2fm_pkg::cmd_t  din,
    input  logic              pop,
    output psg2fm_pkg::cmd_t  dout,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psg2fm_pkg::cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/psg2fm_front.sv */
// Decode front: tracks sound chip latch and registers and queues write commands.
`timescale 1ns / 1ps

module psg2fm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              op,
    input  logic [7:0]        wr_byte,
    input  logic              stereo_enable,
    output logic              push,
    output psg2fm_pkg::cmd_t  cmd
);

    logic [2:0] latched_reg;
    logic [9:0] tone_reg [4];
    logic [3:0] noise_reg;
    logic [3:0] vol3_reg;
    logic [3:0] sent_reg [4];
    logic [1:0] pan3_reg;

    logic        is_latch;
    logic [2:0]  r;
    logic [1:0]  c;
    logic [9:0]  tone_new;
    logic [3:0]  noise_new;
    logic        vol_changed;

    always_comb begin
        is_latch    = wr_byte[7];
        r           = is_latch ? wr_byte[6:4] : latched_reg;
        c           = r[2:1];
        tone_new    = is_latch ? {tone_reg[c][9:4], wr_byte[3:0]}
                               : {wr_byte[5:0], tone_reg[c][3:0]};
        noise_new   = wr_byte[3:0];
        vol_changed = (wr_byte[3:0] != sent_reg[c]);

        push           = 1'b0;
        cmd            = '0;
        cmd.voice      = c;
        cmd.noise_sel  = noise_reg[2];
        cmd.vol        = vol3_reg;
        cmd.pan3       = pan3_reg;
        cmd.mask       = wr_byte;
        cmd.tone_per   = tone_new;

        if (op) begin
            cmd.kind = psg2fm_pkg::CMD_STEREO;
            push     = accept && stereo_enable;
        end else begin
            unique case (r)
                3'd0, 3'd2, 3'd4: begin
                    cmd.kind       = psg2fm_pkg::CMD_TONE;
                    cmd.with_noise = (r == 3'd4) && (noise_reg[1:0] == 2'b11);
                    cmd.noise_per  = {tone_new, 1'b0};
                    push           = accept && !is_latch;
                end
                3'd6: begin
                    cmd.kind      = psg2fm_pkg::CMD_NOISE;
                    cmd.noise_sel = noise_new[2];
                    cmd.noise_per = (noise_new[1:0] == 2'b11) ? {tone_reg[2], 1'b0}
                                  : 11'(11'd1 << (3'd5 + 3'(noise_new[1:0])));
                    push          = accept;
                end
                default: begin
                    cmd.kind = psg2fm_pkg::CMD_VOLUME;
                    cmd.vol  = wr_byte[3:0];
                    push     = accept && vol_changed;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg <= '0;
            noise_reg   <= '0;
            vol3_reg    <= 4'hF;
            pan3_reg    <= 2'b11;
            for (int i = 0; i < 4; i++) begin
                tone_reg[i] <= '0;
                sent_reg[i] <= 4'hF;
            end
        end else if (accept) begin
            if (op) begin
                if (stereo_enable) begin
                    pan3_reg <= {wr_byte[3], wr_byte[7]};
                end
            end else begin
                if (is_latch) begin
                    latched_reg <= r;
                end
                unique case (r)
                    3'd0, 3'd2, 3'd4: tone_reg[c] <= tone_new;
                    3'd6:             noise_reg   <= noise_new;
                    default: begin
                        if (r == 3'd7) begin
                            vol3_reg <= wr_byte[3:0];
                        end
                        sent_reg[c] <= wr_byte[3:0];
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/psg2fm_freq.sv */
// Frequency unit: block search by compares and a serial rounding divide for the F-number.
`timescale 1ns / 1ps

module psg2fm_freq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  psg2fm_pkg::freq_req_t  req,
    input  logic [30:0]            clock_hz,
    output psg2fm_pkg::freq_rsp_t  rsp
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_CHK,
        F_BLK,
        F_DIV,
        F_DONE
    } fstate_t;

    fstate_t     state_reg;
    logic [18:0] d_reg;
    logic        capped_reg;
    logic [40:0] rate_reg;
    logic [37:0] clk72_reg;
    logic [27:0] d440_reg;
    logic [35:0] cmp_reg;
    logic [2:0]  blk_reg;
    logic [59:0] rem_reg;
    logic [51:0] dsh_reg;
    logic [10:0] q_reg;
    logic [3:0]  step_reg;
    logic        done_reg;
    logic [9:0]  fnum_reg;

    logic        too_fast;
    logic        too_low;
    logic        too_high;
    logic        blk_up;
    logic [57:0] num_sh;
    logic [59:0] div_n;
    logic        div_ge;

    always_comb begin
        too_fast = capped_reg && (41'(clk72_reg) > rate_reg);
        too_low  = ({clock_hz, 6'b0} <= 37'(d440_reg));
        too_high = (clock_hz >= {d440_reg, 3'b0});
        blk_up   = (blk_reg != 3'd7) && ({clock_hz, 5'b0} >= cmp_reg);
        num_sh   = 58'(clk72_reg) << (5'd20 - 5'(blk_reg));
        div_n    = 60'({num_sh, 1'b0}) + 60'(rate_reg);
        div_ge   = (rem_reg >= 60'(dsh_reg));
    end

    assign rsp = '{done: done_reg, blk: blk_reg, fnum: fnum_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                F_IDLE: begin
                    if (req.start) begin
                        d_reg      <= req.d;
                        capped_reg <= req.capped;
                        state_reg  <= F_MUL;
                    end
                end
                F_MUL: begin
                    rate_reg  <= 41'(psg2fm_pkg::FM_RATE_NUM) * 41'(d_reg);
                    clk72_reg <= 38'({clock_hz, 6'b0}) + 38'({clock_hz, 3'b0});
                    d440_reg  <= 28'(d_reg) * 28'd440;
                    state_reg <= F_CHK;
                end
                F_CHK: begin
                    if (d_reg == '0 || clock_hz == '0 || too_fast || too_low) begin
                        blk_reg   <= '0;
                        fnum_reg  <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= F_IDLE;
                    end else if (too_high) begin
                        blk_reg   <= 3'd7;
                        fnum_reg  <= 10'h3FF;
                        done_reg  <= 1'b1;
                        state_reg <= F_IDLE;
                    end else begin
                        blk_reg   <= '0;
                        cmp_reg   <= 36'({d440_reg, 1'b0});
                        state_reg <= F_BLK;
                    end
                end
                F_BLK: begin
                    if (blk_up) begin
                        blk_reg <= blk_reg + 3'd1;
                        cmp_reg <= {cmp_reg[34:0], 1'b0};
                    end else begin
                        rem_reg   <= div_n;
                        dsh_reg   <= {rate_reg, 11'b0};
                        q_reg     <= '0;
                        step_reg  <= 4'd10;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (div_ge) begin
                        rem_reg <= rem_reg - 60'(dsh_reg);
                    end
                    q_reg   <= {q_reg[9:0], div_ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (step_reg == '0) begin
                        state_reg <= F_DONE;
                    end else begin
                        step_reg <= step_reg - 4'd1;
                    end
                end
                F_DONE: begin
                    fnum_reg  <= q_reg[10] ? 10'h3FF : q_reg[9:0];
                    done_reg  <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/psg2fm_back.sv */
// Write sequencer: turns queued commands into FM register write beats.
`timescale 1ns / 1ps

module psg2fm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  psg2fm_pkg::cmd_t       cmd_in,
    input  logic                   empty,
    output logic                   pop,
    input  logic                   tone_mode,
    output psg2fm_pkg::freq_req_t  freq_req,
    input  psg2fm_pkg::freq_rsp_t  freq_rsp,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tlast
);

    localparam logic [7:0] FM_LEVEL       = 8'h40;
    localparam logic [7:0] FM_LEVEL_NOISE = 8'h48;
    localparam logic [7:0] FM_LEVEL_V3    = 8'h4B;
    localparam logic [7:0] FM_FNUM_LO     = 8'hA0;
    localparam logic [7:0] FM_KEY_BLK     = 8'hB0;
    localparam logic [7:0] FM_FB_CONN     = 8'hC0;

    typedef enum logic [3:0] {
        B_IDLE,
        B_STEREO,
        B_VOL48,
        B_VOL4X,
        B_TSTART,
        B_TWAIT,
        B_TA,
        B_TB,
        B_NC3,
        B_N48,
        B_NB3Z,
        B_NSTART,
        B_NWAIT,
        B_NA,
        B_NB
    } bstate_t;

    bstate_t           state_reg, state_next;
    psg2fm_pkg::cmd_t  cmd_reg, cmd_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              m_valid_reg;
    logic [7:0]        m_addr_reg;
    logic [7:0]        m_val_reg;
    logic              m_last_reg;

    logic              out_free;
    logic              em;
    logic [7:0]        em_addr;
    logic [7:0]        em_val;
    logic              em_last;
    logic [3:0]        noise_word;
    logic [3:0]        low4;
    logic [1:0]        pan_i;

    assign out_free   = !m_valid_reg || m_tready;
    assign noise_word = cmd_reg.noise_sel ? psg2fm_pkg::NOISE_WORD_PERIODIC
                                          : psg2fm_pkg::NOISE_WORD_WHITE;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {m_val_reg, m_addr_reg};
    assign m_tlast    = m_last_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        em         = 1'b0;
        em_addr    = '0;
        em_val     = '0;
        em_last    = 1'b0;
        freq_req   = '0;
        pan_i      = {cmd_reg.mask[cnt_reg], cmd_reg.mask[3'd4 + 3'(cnt_reg)]};
        low4       = (cnt_reg == 2'd3) ? noise_word : {3'b000, tone_mode};

        unique case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop      = 1'b1;
                    cmd_next = cmd_in;
                    cnt_next = '0;
                    unique case (cmd_in.kind)
                        psg2fm_pkg::CMD_STEREO: state_next = B_STEREO;
                        psg2fm_pkg::CMD_VOLUME: begin
                            state_next = (cmd_in.voice == 2'd3 && !cmd_in.noise_sel)
                                       ? B_VOL48 : B_VOL4X;
                        end
                        psg2fm_pkg::CMD_TONE:   state_next = B_TSTART;
                        default:                state_next = B_NC3;
                    endcase
                end
            end
            B_STEREO: begin
                em      = 1'b1;
                em_addr = FM_FB_CONN | 8'(cnt_reg);
                em_val  = {2'b00, pan_i, low4};
                em_last = (cnt_reg == 2'd3);
                if (out_free) begin
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_VOL48: begin
                em      = 1'b1;
                em_addr = FM_LEVEL_NOISE;
                em_val  = psg2fm_pkg::vol_map(cmd_reg.vol);
                if (out_free) begin
                    state_next = B_VOL4X;
                end
            end
            B_VOL4X: begin
                em      = 1'b1;
                em_addr = (cmd_reg.voice == 2'd3) ? FM_LEVEL_V3
                        : FM_LEVEL | (8'(cmd_reg.voice) + 8'd3);
                em_val  = psg2fm_pkg::vol_map(cmd_reg.vol);
                em_last = 1'b1;
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            B_TSTART: begin
                freq_req.start  = 1'b1;
                freq_req.d      = 19'({cmd_reg.tone_per, 5'b0});
                freq_req.capped = 1'b1;
                state_next      = B_TWAIT;
            end
            B_TWAIT: begin
                if (freq_rsp.done) begin
                    state_next = B_TA;
                end
            end
            B_TA: begin
                em      = 1'b1;
                em_addr = FM_FNUM_LO | 8'(cmd_reg.voice);
                em_val  = freq_rsp.fnum[7:0];
                if (out_free) begin
                    state_next = B_TB;
                end
            end
            B_TB: begin
                em      = 1'b1;
                em_addr = FM_KEY_BLK | 8'(cmd_reg.voice);
                em_val  = {3'b001, freq_rsp.blk, freq_rsp.fnum[9:8]};
                em_last = !cmd_reg.with_noise;
                if (out_free) begin
                    state_next = cmd_reg.with_noise ? B_NC3 : B_IDLE;
                end
            end
            B_NC3: begin
                em      = 1'b1;
                em_addr = FM_FB_CONN | 8'd3;
                em_val  = {2'b00, cmd_reg.pan3, noise_word};
                if (out_free) begin
                    state_next = B_N48;
                end
            end
            B_N48: begin
                em      = 1'b1;
                em_addr = FM_LEVEL_NOISE;
                em_val  = cmd_reg.noise_sel ? 8'h00 : psg2fm_pkg::vol_map(cmd_reg.vol);
                if (out_free) begin
                    state_next = B_NB3Z;
                end
            end
            B_NB3Z: begin
                em      = 1'b1;
                em_addr = FM_KEY_BLK | 8'd3;
                em_val  = 8'h00;
                if (out_free) begin
                    state_next = B_NSTART;
                end
            end
            B_NSTART: begin
                freq_req.start  = 1'b1;
                freq_req.d      = cmd_reg.noise_sel ? {cmd_reg.noise_per, 8'b0}
                                                    : 19'({cmd_reg.noise_per, 5'b0});
                freq_req.capped = 1'b0;
                state_next      = B_NWAIT;
            end
            B_NWAIT: begin
                if (freq_rsp.done) begin
                    state_next = B_NA;
                end
            end
            B_NA: begin
                em      = 1'b1;
                em_addr = FM_FNUM_LO | 8'd3;
                em_val  = freq_rsp.fnum[7:0];
                if (out_free) begin
                    state_next = B_NB;
                end
            end
            B_NB: begin
                em      = 1'b1;
                em_addr = FM_KEY_BLK | 8'd3;
                em_val  = {3'b001, freq_rsp.blk, freq_rsp.fnum[9:8]};
                em_last = 1'b1;
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
            if (out_free) begin
                m_valid_reg <= em;
                if (em) begin
                    m_addr_reg <= em_addr;
                    m_val_reg  <= em_val;
                    m_last_reg <= em_last;
                end
            end
        end
    end

endmodule
